// ===== src/plt_pkg.sv =====
// Shared types, character codes and helpers for the polyline text parser.
// No dependencies; every other file in src/ imports this package.
package plt_pkg;

    // Fixed field widths
    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int COORD_W = 32;
    localparam int DIGIT_W = 4;

    // Default numeric format
    localparam int DEF_INT_BITS    = 16;
    localparam int DEF_FRAC_BITS   = 16;
    localparam int DEF_FRAC_DIGITS = 6;

    // Character codes
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CH_POINT = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_BAR   = 8'h7C;
    localparam logic [BYTE_W-1:0] CH_V     = 8'h76;

    // Result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_VERTEX    = 2'd0,
        KIND_STRIP_END = 2'd1,
        KIND_DROP      = 2'd2
    } kind_t;

    // Byte classes produced by the front end
    typedef enum logic [2:0] {
        TOK_DIGIT,
        TOK_POINT,
        TOK_BAR,
        TOK_V,
        TOK_OTHER
    } tok_class_t;

    typedef struct packed {
        tok_class_t         cls;
        logic [DIGIT_W-1:0] digit;
        logic               eod;
    } tok_t;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Back end sequencer
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_CLOSE,
        BK_EMIT
    } back_state_t;

    // Decimal scale for a fraction of n digits
    function automatic logic [31:0] pow10(input logic [3:0] n);
        logic [31:0] p;
        case (n)
            4'd0:    p = 32'd1;
            4'd1:    p = 32'd10;
            4'd2:    p = 32'd100;
            4'd3:    p = 32'd1000;
            4'd4:    p = 32'd10000;
            4'd5:    p = 32'd100000;
            4'd6:    p = 32'd1000000;
            4'd7:    p = 32'd10000000;
            4'd8:    p = 32'd100000000;
            4'd9:    p = 32'd1000000000;
            default: p = 32'd1;
        endcase
        return p;
    endfunction

endpackage

// ===== src/plt_byte_if.sv =====
// Input channel of the polyline text parser: one text byte per item.
// Depends on plt_pkg for field widths.
interface plt_byte_if;
    import plt_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] text_byte;
    logic              end_of_data;

    modport source (output valid, text_byte, end_of_data, input ready);
    modport sink   (input valid, text_byte, end_of_data, output ready);
endinterface

// ===== src/plt_result_if.sv =====
// Output channel of the polyline text parser: one vertex or strip event per item.
// Depends on plt_pkg for field widths.
interface plt_result_if;
    import plt_pkg::*;

    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [COORD_W-1:0] x_pos;
    logic [COORD_W-1:0] y_pos;
    logic               saturated;
    logic               last_of_run;

    modport source (output valid, kind, x_pos, y_pos, saturated, last_of_run, input ready);
    modport sink   (input valid, kind, x_pos, y_pos, saturated, last_of_run, output ready);
endinterface

// ===== src/plt_front.sv =====
// Front end: accepts text bytes and classifies them into tokens for the queue.
// Depends on plt_pkg and plt_byte_if.
module plt_front (
    plt_byte_if.sink          byte_in,
    input  plt_pkg::q_status_t q_stat,
    output logic              push,
    output plt_pkg::tok_t     push_tok
);
    import plt_pkg::*;

    logic [BYTE_W-1:0] digit_off;

    // Take a byte whenever the queue has room
    assign byte_in.ready = !q_stat.full;
    assign push          = byte_in.valid && !q_stat.full;

    assign digit_off = byte_in.text_byte - CH_ZERO;

    // Byte classification
    always_comb
    begin
        push_tok.eod   = byte_in.end_of_data;
        push_tok.digit = digit_off[DIGIT_W-1:0];
        if (byte_in.text_byte >= CH_ZERO && byte_in.text_byte <= CH_NINE)
        begin
            push_tok.cls = TOK_DIGIT;
        end
        else if (byte_in.text_byte == CH_POINT)
        begin
            push_tok.cls = TOK_POINT;
        end
        else if (byte_in.text_byte == CH_BAR)
        begin
            push_tok.cls = TOK_BAR;
        end
        else if (byte_in.text_byte == CH_V)
        begin
            push_tok.cls = TOK_V;
        end
        else
        begin
            push_tok.cls = TOK_OTHER;
        end
    end
endmodule

// ===== src/plt_queue.sv =====
// Short token queue between the front end and the back end.
// Depends on plt_pkg.
module plt_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  plt_pkg::tok_t      push_tok,
    input  logic               pop,
    output plt_pkg::tok_t      head_tok,
    output plt_pkg::q_status_t q_stat
);
    import plt_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    tok_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign q_stat.full  = (cnt_reg == CNT_W'(DEPTH));
    assign q_stat.empty = (cnt_reg == '0);
    assign head_tok     = slot_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Token storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_tok;
        end
    end
endmodule

// ===== src/plt_back.sv =====
// Back end: number accumulation, bit-serial fraction divider, vertex pairing
// and the result output register. Depends on plt_pkg and plt_result_if.
module plt_back #(
    parameter int INT_BITS    = plt_pkg::DEF_INT_BITS,
    parameter int FRAC_BITS   = plt_pkg::DEF_FRAC_BITS,
    parameter int FRAC_DIGITS = plt_pkg::DEF_FRAC_DIGITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  plt_pkg::tok_t      head_tok,
    input  plt_pkg::q_status_t q_stat,
    output logic               pop,
    plt_result_if.source       result_out
);
    import plt_pkg::*;

    localparam int POW_MAX  = 10 ** FRAC_DIGITS;
    localparam int DIV_W    = $clog2(POW_MAX);
    localparam int FCNT_W   = $clog2(FRAC_DIGITS + 1);
    localparam int DCNT_W   = $clog2(FRAC_BITS + 1);
    localparam int NUM_W    = INT_BITS + FRAC_BITS;
    localparam int NV_W     = INT_BITS + 4;
    localparam int FNV_W    = DIV_W + 4;

    back_state_t        st_reg, st_next;

    // Parser state
    logic               mode_reg, mode_next;
    logic [INT_BITS-1:0] int_reg, int_next;
    logic [DIV_W-1:0]   frac_reg, frac_next;
    logic [FCNT_W-1:0]  fcnt_reg, fcnt_next;
    logic               point_reg, point_next;
    logic               extra_reg, extra_next;
    logic               open_reg, open_next;
    logic               csel_reg, csel_next;
    logic [COORD_W-1:0] first_reg, first_next;
    logic               sat_reg, sat_next;

    // Delimiter token held while it is worked off
    logic               bar_reg, bar_next;
    logic               eod_reg, eod_next;

    // Fraction divider
    logic [DIV_W-1:0]     rem_reg, rem_next;
    logic [DIV_W-1:0]     dvs_reg, dvs_next;
    logic [FRAC_BITS-1:0] quot_reg, quot_next;
    logic [DCNT_W-1:0]    dcnt_reg, dcnt_next;

    // Pending results
    logic               pvtx_reg, pvtx_next;
    logic               pend_reg, pend_next;
    logic               pdrop_reg, pdrop_next;
    logic [COORD_W-1:0] vx_reg, vx_next;
    logic [COORD_W-1:0] vy_reg, vy_next;
    logic               vsat_reg, vsat_next;

    // Output register
    logic               ov_reg, ov_next;
    kind_t              okind_reg, okind_next;
    logic [COORD_W-1:0] ox_reg, ox_next;
    logic [COORD_W-1:0] oy_reg, oy_next;
    logic               osat_reg, osat_next;
    logic               olast_reg, olast_next;

    // Datapath helpers
    logic [NV_W-1:0]    int_ext, int_nv;
    logic [FNV_W-1:0]   frac_ext, frac_nv;
    logic               int_ovf;
    logic [DIV_W:0]     rem2;
    logic               rem_ge;
    logic [NUM_W-1:0]   num_full;
    logic [COORD_W-1:0] coord;
    logic               out_free;
    logic               clear_num;
    logic               do_reset;

    assign int_ext  = {4'b0, int_reg};
    assign int_nv   = (int_ext << 3) + (int_ext << 1) + NV_W'(head_tok.digit);
    assign int_ovf  = |int_nv[NV_W-1:INT_BITS];
    assign frac_ext = {4'b0, frac_reg};
    assign frac_nv  = (frac_ext << 3) + (frac_ext << 1) + FNV_W'(head_tok.digit);

    assign rem2     = {rem_reg, 1'b0};
    assign rem_ge   = (rem2 >= {1'b0, dvs_reg});
    assign num_full = {int_reg, quot_reg};
    assign coord    = COORD_W'(num_full);

    assign out_free = !ov_reg || result_out.ready;
    assign pop      = (st_reg == BK_IDLE) && !q_stat.empty;

    // Sequencer and next-state logic
    always_comb
    begin
        st_next    = st_reg;
        mode_next  = mode_reg;
        int_next   = int_reg;
        frac_next  = frac_reg;
        fcnt_next  = fcnt_reg;
        point_next = point_reg;
        extra_next = extra_reg;
        open_next  = open_reg;
        csel_next  = csel_reg;
        first_next = first_reg;
        sat_next   = sat_reg;
        bar_next   = bar_reg;
        eod_next   = eod_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        quot_next  = quot_reg;
        dcnt_next  = dcnt_reg;
        pvtx_next  = pvtx_reg;
        pend_next  = pend_reg;
        pdrop_next = pdrop_reg;
        vx_next    = vx_reg;
        vy_next    = vy_reg;
        vsat_next  = vsat_reg;
        ov_next    = ov_reg && !result_out.ready;
        okind_next = okind_reg;
        ox_next    = ox_reg;
        oy_next    = oy_reg;
        osat_next  = osat_reg;
        olast_next = olast_reg;
        clear_num  = 1'b0;
        do_reset   = 1'b0;

        case (st_reg)
            BK_IDLE:
            begin
                if (pop)
                begin
                    if (!mode_reg)
                    begin
                        // Searching: only 'v' opens a strip
                        if (head_tok.cls == TOK_V)
                        begin
                            mode_next = 1'b1;
                            clear_num = 1'b1;
                            csel_next = 1'b0;
                            sat_next  = 1'b0;
                        end
                        if (head_tok.eod)
                        begin
                            do_reset = 1'b1;
                            if (head_tok.cls == TOK_V)
                            begin
                                pdrop_next = 1'b1;
                                st_next    = BK_EMIT;
                            end
                        end
                    end
                    else
                    begin
                        case (head_tok.cls)
                            TOK_DIGIT:
                            begin
                                open_next = 1'b1;
                                if (!point_reg)
                                begin
                                    if (int_ovf)
                                    begin
                                        int_next = '1;
                                        sat_next = 1'b1;
                                    end
                                    else
                                    begin
                                        int_next = int_nv[INT_BITS-1:0];
                                    end
                                end
                                else if (!extra_reg && fcnt_reg < FCNT_W'(FRAC_DIGITS))
                                begin
                                    frac_next = frac_nv[DIV_W-1:0];
                                    fcnt_next = fcnt_reg + 1'b1;
                                end
                            end
                            TOK_POINT:
                            begin
                                open_next = 1'b1;
                                if (point_reg)
                                begin
                                    extra_next = 1'b1;
                                end
                                point_next = 1'b1;
                            end
                            default:
                            begin
                                // Delimiter: convert the open number first
                                bar_next = (head_tok.cls == TOK_BAR);
                                eod_next = head_tok.eod;
                                if (open_reg)
                                begin
                                    rem_next  = frac_reg;
                                    dvs_next  = DIV_W'(pow10(4'(fcnt_reg)));
                                    dcnt_next = DCNT_W'(FRAC_BITS);
                                    st_next   = BK_DIV;
                                end
                                else
                                begin
                                    st_next = BK_CLOSE;
                                end
                            end
                        endcase
                        if ((head_tok.cls == TOK_DIGIT || head_tok.cls == TOK_POINT)
                            && head_tok.eod)
                        begin
                            do_reset   = 1'b1;
                            pdrop_next = 1'b1;
                            st_next    = BK_EMIT;
                        end
                    end
                end
            end

            BK_DIV:
            begin
                // One quotient bit per cycle, restoring
                rem_next  = DIV_W'(rem_ge ? rem2 - {1'b0, dvs_reg} : rem2);
                quot_next = {quot_reg[FRAC_BITS-2:0], rem_ge};
                dcnt_next = dcnt_reg - 1'b1;
                if (dcnt_reg == DCNT_W'(1))
                begin
                    st_next = BK_CLOSE;
                end
            end

            BK_CLOSE:
            begin
                if (open_reg)
                begin
                    clear_num = 1'b1;
                    if (!csel_reg)
                    begin
                        first_next = coord;
                        csel_next  = 1'b1;
                    end
                    else
                    begin
                        pvtx_next = 1'b1;
                        vx_next   = first_reg;
                        vy_next   = coord;
                        vsat_next = sat_reg;
                        csel_next = 1'b0;
                        sat_next  = 1'b0;
                    end
                end
                if (bar_reg)
                begin
                    pend_next  = 1'b1;
                    mode_next  = 1'b0;
                    csel_next  = 1'b0;
                    first_next = '0;
                    sat_next   = 1'b0;
                end
                if (eod_reg)
                begin
                    do_reset = 1'b1;
                    if (!bar_reg)
                    begin
                        pdrop_next = 1'b1;
                    end
                end
                if ((open_reg && csel_reg) || bar_reg || eod_reg)
                begin
                    st_next = BK_EMIT;
                end
                else
                begin
                    st_next = BK_IDLE;
                end
            end

            BK_EMIT:
            begin
                // Hand pending results to the output register in order
                if (out_free)
                begin
                    ov_next   = 1'b1;
                    ox_next   = '0;
                    oy_next   = '0;
                    osat_next = 1'b0;
                    if (pvtx_reg)
                    begin
                        okind_next = KIND_VERTEX;
                        ox_next    = vx_reg;
                        oy_next    = vy_reg;
                        osat_next  = vsat_reg;
                        olast_next = !(pend_reg || pdrop_reg);
                        pvtx_next  = 1'b0;
                        if (!(pend_reg || pdrop_reg))
                        begin
                            st_next = BK_IDLE;
                        end
                    end
                    else if (pend_reg)
                    begin
                        okind_next = KIND_STRIP_END;
                        olast_next = !pdrop_reg;
                        pend_next  = 1'b0;
                        if (!pdrop_reg)
                        begin
                            st_next = BK_IDLE;
                        end
                    end
                    else
                    begin
                        okind_next = KIND_DROP;
                        olast_next = 1'b1;
                        pdrop_next = 1'b0;
                        st_next    = BK_IDLE;
                    end
                end
            end

            default:
            begin
                st_next = BK_IDLE;
            end
        endcase

        // Number accumulator clear
        if (clear_num)
        begin
            int_next   = '0;
            frac_next  = '0;
            fcnt_next  = '0;
            point_next = 1'b0;
            extra_next = 1'b0;
            open_next  = 1'b0;
        end

        // Return to the reset state at end of data
        if (do_reset)
        begin
            mode_next  = 1'b0;
            int_next   = '0;
            frac_next  = '0;
            fcnt_next  = '0;
            point_next = 1'b0;
            extra_next = 1'b0;
            open_next  = 1'b0;
            csel_next  = 1'b0;
            first_next = '0;
            sat_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= BK_IDLE;
            mode_reg  <= 1'b0;
            int_reg   <= '0;
            frac_reg  <= '0;
            fcnt_reg  <= '0;
            point_reg <= 1'b0;
            extra_reg <= 1'b0;
            open_reg  <= 1'b0;
            csel_reg  <= 1'b0;
            first_reg <= '0;
            sat_reg   <= 1'b0;
            bar_reg   <= 1'b0;
            eod_reg   <= 1'b0;
            dcnt_reg  <= '0;
            pvtx_reg  <= 1'b0;
            pend_reg  <= 1'b0;
            pdrop_reg <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            st_reg    <= st_next;
            mode_reg  <= mode_next;
            int_reg   <= int_next;
            frac_reg  <= frac_next;
            fcnt_reg  <= fcnt_next;
            point_reg <= point_next;
            extra_reg <= extra_next;
            open_reg  <= open_next;
            csel_reg  <= csel_next;
            first_reg <= first_next;
            sat_reg   <= sat_next;
            bar_reg   <= bar_next;
            eod_reg   <= eod_next;
            dcnt_reg  <= dcnt_next;
            pvtx_reg  <= pvtx_next;
            pend_reg  <= pend_next;
            pdrop_reg <= pdrop_next;
            ov_reg    <= ov_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        dvs_reg   <= dvs_next;
        quot_reg  <= quot_next;
        vx_reg    <= vx_next;
        vy_reg    <= vy_next;
        vsat_reg  <= vsat_next;
        okind_reg <= okind_next;
        ox_reg    <= ox_next;
        oy_reg    <= oy_next;
        osat_reg  <= osat_next;
        olast_reg <= olast_next;
    end

    assign result_out.valid       = ov_reg;
    assign result_out.kind        = okind_reg;
    assign result_out.x_pos       = ox_reg;
    assign result_out.y_pos       = oy_reg;
    assign result_out.saturated   = osat_reg;
    assign result_out.last_of_run = olast_reg;
endmodule

// ===== src/polyline_text_parser.sv =====
// Polyline text parser: reads map text a byte at a time and emits strip vertices in
// unsigned fixed point (INT_BITS.FRAC_BITS, low 32 bits), strip ends and dropped strips.
// Depends on plt_pkg, plt_byte_if, plt_result_if, plt_front, plt_queue, plt_back.
//
// Bytes enter a four-token queue, so the input keeps taking one byte per cycle while
// the back end is busy, until the queue is full. Digits, points and bytes skipped
// while searching for 'v' are worked off at one per cycle. A delimiter that closes an
// open number runs the bit-serial fraction divider (one quotient bit per cycle) and
// then BK_CLOSE; a delimiter with no open number goes straight to BK_CLOSE. Each
// result passes the output register, which holds a finished result as the back end goes on.
module polyline_text_parser #(
    parameter int INT_BITS    = plt_pkg::DEF_INT_BITS,
    parameter int FRAC_BITS   = plt_pkg::DEF_FRAC_BITS,
    parameter int FRAC_DIGITS = plt_pkg::DEF_FRAC_DIGITS
) (
    input  logic         clk,
    input  logic         rst_n,
    plt_byte_if.sink     byte_in,
    plt_result_if.source result_out
);
    import plt_pkg::*;

    q_status_t q_stat;
    tok_t      push_tok;
    tok_t      head_tok;
    logic      push;
    logic      pop;

    plt_front u_front (
        .byte_in  (byte_in),
        .q_stat   (q_stat),
        .push     (push),
        .push_tok (push_tok)
    );

    plt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_tok (push_tok),
        .pop      (pop),
        .head_tok (head_tok),
        .q_stat   (q_stat)
    );

    plt_back #(
        .INT_BITS    (INT_BITS),
        .FRAC_BITS   (FRAC_BITS),
        .FRAC_DIGITS (FRAC_DIGITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_tok   (head_tok),
        .q_stat     (q_stat),
        .pop        (pop),
        .result_out (result_out)
    );

    // A full queue must hold off the input
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.full |-> !byte_in.ready)
        else $error("byte accepted while token queue full");

    // Back end never pops an empty queue
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.empty |-> !pop)
        else $error("token popped from empty queue");

    // Strip events carry no coordinates
    a_event_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_out.valid && result_out.kind != KIND_VERTEX |->
            result_out.x_pos == '0 && result_out.y_pos == '0 && !result_out.saturated)
        else $error("strip event with nonzero payload");

    // A dropped strip is always the final result of its byte
    a_drop_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_out.valid && result_out.kind == KIND_DROP |-> result_out.last_of_run)
        else $error("dropped-strip result not marked last");
endmodule
